[rtl/sfd_pkg.sv]
`default_nettype none

package sfd_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int COEF_W            = 16;
   localparam int FRAC_BITS         = 15;
   localparam int COEF_STORED       = 10;
   localparam int COEF_IDX_W        = $clog2(COEF_STORED);
   localparam int TAP_COUNT_DEFAULT = 20;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // Q1.15 coefficients, outermost tap first
   localparam coef_type COEF_TAB [COEF_STORED] = '{
      16'sd340,   16'sd776,   16'sd320,   -16'sd885,  -16'sd2941,
      -16'sd3616, -16'sd1699, 16'sd5076,  16'sd18643, 16'sd25965
   };

   typedef struct packed {
      sample_type early_i;
      sample_type early_q;
      sample_type late_i;
      sample_type late_q;
   } req_payload_type;

   typedef struct packed {
      sample_type out_i;
      sample_type out_q;
   } rsp_payload_type;

   // advance enables for the filter pipeline stages
   typedef struct packed {
      logic prod_en;
      logic part_en;
      logic out_en;
   } stage_en_type;

   // symmetric coefficient for tap k; inner taps beyond the table are zero
   function automatic coef_type coef_at(input int k, input int taps);
      int j;
      int c;
      j = taps - 1 - k;
      c = (k < j) ? k : j;
      if (c < 0 || c >= COEF_STORED) begin
         return '0;
      end
      return COEF_TAB[c[COEF_IDX_W-1:0]];
   endfunction

endpackage

`default_nettype wire

[rtl/sfd_rail.sv]
`default_nettype none

module sfd_rail
   import sfd_pkg::*;
#(
   parameter int TAP_COUNT = TAP_COUNT_DEFAULT
) (
   input  wire logic         clock,
   input  wire stage_en_type stage_en,
   input  wire sample_type   window [TAP_COUNT],
   output sample_type        result
);

   localparam int PAIRS  = (TAP_COUNT + 1) / 2;
   localparam int GROUPS = (PAIRS + 3) / 4;
   localparam int PRE_W  = SAMPLE_W + 1;
   localparam int PROD_W = PRE_W + COEF_W;
   localparam int PART_W = PROD_W + 2;
   localparam int ACC_W  = PART_W + $clog2(GROUPS) + 1;

   localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO  = ~SAT_HI;

   logic signed [PRE_W-1:0]  pre_sum [PAIRS];
   logic signed [PROD_W-1:0] prod_in [PAIRS];
   logic signed [PROD_W-1:0] prod_ff [PAIRS];
   logic signed [PART_W-1:0] part_in [GROUPS];
   logic signed [PART_W-1:0] part_ff [GROUPS];
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rounded;
   sample_type               result_in;
   sample_type               result_ff;

   // fold mirrored taps, then scale by the shared coefficient
   always_comb begin
      for (int k = 0; k < PAIRS; k++) begin
         if (k == TAP_COUNT - 1 - k) begin
            pre_sum[k] = PRE_W'(window[k]);
         end else begin
            pre_sum[k] = PRE_W'(window[k]) + PRE_W'(window[TAP_COUNT - 1 - k]);
         end
         prod_in[k] = PROD_W'(pre_sum[k]) * PROD_W'(coef_at(k, TAP_COUNT));
      end
   end

   // partial sums over groups of four products
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int m = 0; m < 4; m++) begin
            if (g * 4 + m < PAIRS) begin
               part_in[g] = part_in[g] + PART_W'(prod_ff[g * 4 + m]);
            end
         end
      end
   end

   // final sum, round half up, saturate
   always_comb begin
      acc = '0;
      for (int g = 0; g < GROUPS; g++) begin
         acc = acc + ACC_W'(part_ff[g]);
      end
      rounded = (acc + ROUND_C) >>> FRAC_BITS;
      if (rounded > SAT_HI) begin
         result_in = SAMPLE_W'(SAT_HI);
      end else if (rounded < SAT_LO) begin
         result_in = SAMPLE_W'(SAT_LO);
      end else begin
         result_in = SAMPLE_W'(rounded);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.prod_en) begin
         prod_ff <= prod_in;
      end
      if (stage_en.part_en) begin
         part_ff <= part_in;
      end
      if (stage_en.out_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/symmetric_fir_decimate_by_two_core.sv]
`default_nettype none

// Complex symmetric FIR with decimation by two. Each request beat carries a
// pair of complex samples (early, late); each response beat carries one
// filtered complex sample, rounded half up and saturated to 16 bits. The I and
// Q rails share the same TAP_COUNT-tap symmetric Q1.15 coefficient set and the
// filter history starts at zero after reset. One beat is taken per clock
// while the response side does not stall: the window register shifts by two
// samples on each accept and every pipeline stage advances each cycle it is
// not stalled, so throughput is one item per cycle without back-pressure.
// From request accept to rsp_valid a beat passes the window register, which
// loads at the accepting edge, then the folded-product, partial-sum and
// rounded-result registers. Stalls on the response side back up stage by
// stage, and empty stages are filled even while a finished result waits.

module symmetric_fir_decimate_by_two_core
   import sfd_pkg::*;
#(
   parameter int TAP_COUNT = TAP_COUNT_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   // window: newest first, late then early then the history
   sample_type   win_i_ff [TAP_COUNT];
   sample_type   win_q_ff [TAP_COUNT];
   sample_type   win_i_in [TAP_COUNT];
   sample_type   win_q_in [TAP_COUNT];

   logic         win_v_ff;
   logic         prod_v_ff;
   logic         part_v_ff;
   logic         out_v_ff;

   logic         prod_adv;
   logic         part_adv;
   logic         out_adv;
   logic         req_accept;
   stage_en_type stage_en;

   sample_type   rail_i_out;
   sample_type   rail_q_out;

   // a stage may load when it is empty or its contents move on this cycle
   assign out_adv    = !out_v_ff || rsp_ready;
   assign part_adv   = !part_v_ff || out_adv;
   assign prod_adv   = !prod_v_ff || part_adv;
   assign req_ready  = !win_v_ff || prod_adv;
   assign req_accept = req_valid && req_ready;

   assign stage_en.prod_en = prod_adv && win_v_ff;
   assign stage_en.part_en = part_adv && prod_v_ff;
   assign stage_en.out_en  = out_adv && part_v_ff;

   // shift the window by two and drop the new pair in at the front
   always_comb begin
      win_i_in[0] = req_payload.late_i;
      win_i_in[1] = req_payload.early_i;
      win_q_in[0] = req_payload.late_q;
      win_q_in[1] = req_payload.early_q;
      for (int k = 2; k < TAP_COUNT; k++) begin
         win_i_in[k] = win_i_ff[k - 2];
         win_q_in[k] = win_q_ff[k - 2];
      end
   end

   // window doubles as the filter history, so it advances only on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAP_COUNT; k++) begin
            win_i_ff[k] <= '0;
            win_q_ff[k] <= '0;
         end
      end else if (req_accept) begin
         win_i_ff <= win_i_in;
         win_q_ff <= win_q_in;
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         win_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         part_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            win_v_ff <= req_valid;
         end
         if (prod_adv) begin
            prod_v_ff <= win_v_ff;
         end
         if (part_adv) begin
            part_v_ff <= prod_v_ff;
         end
         if (out_adv) begin
            out_v_ff <= part_v_ff;
         end
      end
   end

   sfd_rail #(
      .TAP_COUNT (TAP_COUNT)
   ) u_rail_i (
      .clock    (clock),
      .stage_en (stage_en),
      .window   (win_i_ff),
      .result   (rail_i_out)
   );

   sfd_rail #(
      .TAP_COUNT (TAP_COUNT)
   ) u_rail_q (
      .clock    (clock),
      .stage_en (stage_en),
      .window   (win_q_ff),
      .result   (rail_q_out)
   );

   // out_i sits in the upper half of the response beat
   assign rsp_payload = {rail_i_out, rail_q_out};
   assign rsp_valid   = out_v_ff;

endmodule

`default_nettype wire
